### rtl/nfcl_pkg.sv
// Shared constants and types for the nearest-frequency calibration lookup.
`default_nettype none
package nfcl_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int FREQ_BITS_DEF     = 24;
	localparam int FREQ_IN_W         = 24;
	localparam int VAL_W             = 16;
	localparam int IDX_W             = 5;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_LOOKUP = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] temp;
		logic signed [VAL_W-1:0] i_off;
		logic signed [VAL_W-1:0] q_off;
	} entry_pay_t;

	typedef struct packed {
		logic eq;
		logic lt_cur;
		logic gt_prev;
		logic lower;
	} cmp_flags_t;

endpackage
`default_nettype wire

### rtl/nfcl_if.sv
// Request and response channel interfaces of the calibration lookup.
`default_nettype none
interface nfcl_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             action;
	logic [nfcl_pkg::FREQ_IN_W-1:0]         frequency;
	logic signed [nfcl_pkg::VAL_W-1:0]      temperature;
	logic signed [nfcl_pkg::VAL_W-1:0]      i_offset;
	logic signed [nfcl_pkg::VAL_W-1:0]      q_offset;

	modport source (output valid, action, frequency, temperature, i_offset, q_offset,
		input ready);
	modport sink (input valid, action, frequency, temperature, i_offset, q_offset,
		output ready);
endinterface

interface nfcl_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             status;
	logic [nfcl_pkg::IDX_W-1:0]             entry_index;
	logic signed [nfcl_pkg::VAL_W-1:0]      found_temperature;
	logic signed [nfcl_pkg::VAL_W-1:0]      found_i_offset;
	logic signed [nfcl_pkg::VAL_W-1:0]      found_q_offset;

	modport source (output valid, status, entry_index, found_temperature, found_i_offset,
		found_q_offset, input ready);
	modport sink (input valid, status, entry_index, found_temperature, found_i_offset,
		found_q_offset, output ready);
endinterface
`default_nettype wire

### rtl/nearest_frequency_cal_lookup.sv
// Top level: calibration table with nearest-frequency lookup sequencer.
// Clear and append go straight to S_EMIT; the response is registered once the output is free.
// Lookup walks one stored entry per cycle through the frequency read port and compare unit;
// the walk stops at a hit or the last stored entry, then goes through S_FETCH and S_EMIT.
// One request at a time; req.ready returns in the same cycle that the response turns valid.
// Reset (arst_n low) empties the table and drops any pending response.
`default_nettype none
module nearest_frequency_cal_lookup #(
	parameter int TABLE_ENTRIES = nfcl_pkg::TABLE_ENTRIES_DEF,
	parameter int FREQ_BITS     = nfcl_pkg::FREQ_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	nfcl_req_if.sink    req,
	nfcl_rsp_if.source  rsp
);

	localparam int IW   = $clog2(TABLE_ENTRIES);
	localparam int CW   = $clog2(TABLE_ENTRIES + 1);
	localparam int IdxW = nfcl_pkg::IDX_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FETCH,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	logic [FREQ_BITS-1:0]  f_in;
	logic [FREQ_BITS-1:0]  f_q;
	logic [FREQ_BITS-1:0]  prev_q;
	logic [FREQ_BITS-1:0]  frd_data;
	logic [IW-1:0]         frd_addr;
	logic [IW-1:0]         walk_q;
	logic [IW-1:0]         res_idx_q;
	logic [IW-1:0]         pick_nxt;
	nfcl_pkg::status_t     res_status_q;
	nfcl_pkg::entry_pay_t  res_pay_q;
	logic                  res_mem_q;
	nfcl_pkg::entry_pay_t  in_pay;
	nfcl_pkg::entry_pay_t  pay_rd;
	nfcl_pkg::cmp_flags_t  flags;
	logic                  accept;
	logic                  wr_en;
	logic                  hit;
	logic                  last;
	logic                  out_load;
	logic                  ovalid_q;
	nfcl_pkg::status_t     ostatus_q;
	logic [IdxW-1:0]       oidx_q;
	nfcl_pkg::entry_pay_t  opay_q;

	assign f_in         = FREQ_BITS'(req.frequency);
	assign in_pay.temp  = req.temperature;
	assign in_pay.i_off = req.i_offset;
	assign in_pay.q_off = req.q_offset;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign wr_en     = accept && (req.action == nfcl_pkg::ACT_APPEND)
		&& (cnt_q < CW'(TABLE_ENTRIES));
	assign frd_addr  = (state_q == S_WALK) ? walk_q + IW'(1) : '0;

	assign last     = (CW'(walk_q) + CW'(1)) == cnt_q;
	assign hit      = flags.eq
		|| ((walk_q == '0) ? flags.lt_cur : (flags.gt_prev && flags.lt_cur));
	assign pick_nxt = (!flags.eq && (walk_q != '0) && hit && flags.lower)
		? walk_q - IW'(1) : walk_q;

	assign out_load = (state_q == S_EMIT) && (!ovalid_q || rsp.ready);

	nfcl_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.FREQ_BITS     (FREQ_BITS)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (cnt_q[IW-1:0]),
		.wr_freq  (f_in),
		.wr_pay   (in_pay),
		.frd_addr (frd_addr),
		.frd_data (frd_data),
		.prd_addr (res_idx_q),
		.prd_data (pay_rd)
	);

	nfcl_cmp #(
		.FREQ_BITS (FREQ_BITS)
	) u_cmp (
		.freq  (f_q),
		.prev  (prev_q),
		.cur   (frd_data),
		.flags (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			f_q          <= '0;
			prev_q       <= '0;
			walk_q       <= '0;
			res_idx_q    <= '0;
			res_status_q <= nfcl_pkg::ST_OK;
			res_pay_q    <= '0;
			res_mem_q    <= 1'b0;
			ovalid_q     <= 1'b0;
			ostatus_q    <= nfcl_pkg::ST_OK;
			oidx_q       <= '0;
			opay_q       <= '0;
		end else begin
			if (rsp.ready && !out_load) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.action)
							nfcl_pkg::ACT_CLEAR: begin
								cnt_q        <= '0;
								res_idx_q    <= '0;
								res_status_q <= nfcl_pkg::ST_OK;
								res_pay_q    <= '0;
								res_mem_q    <= 1'b0;
								state_q      <= S_EMIT;
							end
							nfcl_pkg::ACT_APPEND: begin
								res_mem_q <= 1'b0;
								state_q   <= S_EMIT;
								if (wr_en) begin
									cnt_q        <= cnt_q + CW'(1);
									res_idx_q    <= cnt_q[IW-1:0];
									res_pay_q    <= in_pay;
									res_status_q <= nfcl_pkg::ST_OK;
								end else begin
									res_idx_q    <= '0;
									res_pay_q    <= '0;
									res_status_q <= nfcl_pkg::ST_FULL;
								end
							end
							nfcl_pkg::ACT_LOOKUP: begin
								f_q       <= f_in;
								res_idx_q <= '0;
								res_pay_q <= '0;
								if (cnt_q == '0) begin
									res_status_q <= nfcl_pkg::ST_EMPTY;
									res_mem_q    <= 1'b0;
									state_q      <= S_EMIT;
								end else begin
									res_status_q <= nfcl_pkg::ST_OK;
									walk_q       <= '0;
									res_mem_q    <= 1'b1;
									state_q      <= S_WALK;
								end
							end
							default: begin
								res_idx_q    <= '0;
								res_status_q <= nfcl_pkg::ST_OK;
								res_pay_q    <= '0;
								res_mem_q    <= 1'b0;
								state_q      <= S_EMIT;
							end
						endcase
					end
				end
				S_WALK: begin
					if (hit || last) begin
						res_idx_q <= pick_nxt;
						state_q   <= S_FETCH;
					end else begin
						prev_q <= frd_data;
						walk_q <= walk_q + IW'(1);
					end
				end
				S_FETCH: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_load) begin
						ovalid_q  <= 1'b1;
						ostatus_q <= res_status_q;
						oidx_q    <= IdxW'(res_idx_q);
						opay_q    <= res_mem_q ? pay_rd : res_pay_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid             = ovalid_q;
	assign rsp.status            = ostatus_q;
	assign rsp.entry_index       = oidx_q;
	assign rsp.found_temperature = opay_q.temp;
	assign rsp.found_i_offset    = opay_q.i_off;
	assign rsp.found_q_offset    = opay_q.q_off;

endmodule
`default_nettype wire

### rtl/nfcl_table.sv
// Entry storage: frequency memory and payload memory, registered reads.
`default_nettype none
module nfcl_table #(
	parameter int TABLE_ENTRIES = nfcl_pkg::TABLE_ENTRIES_DEF,
	parameter int FREQ_BITS     = nfcl_pkg::FREQ_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
	input  wire logic [FREQ_BITS-1:0]          wr_freq,
	input  wire nfcl_pkg::entry_pay_t          wr_pay,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0] frd_addr,
	output logic [FREQ_BITS-1:0]               frd_data,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0] prd_addr,
	output nfcl_pkg::entry_pay_t               prd_data
);

	logic [FREQ_BITS-1:0]  freq_mem [TABLE_ENTRIES];
	nfcl_pkg::entry_pay_t  pay_mem  [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			freq_mem[wr_addr] <= wr_freq;
			pay_mem[wr_addr]  <= wr_pay;
		end
		frd_data <= freq_mem[frd_addr];
		prd_data <= pay_mem[prd_addr];
	end

endmodule
`default_nettype wire

### rtl/nfcl_cmp.sv
// Shared compare unit: test the request against one entry and its predecessor.
`default_nettype none
module nfcl_cmp #(
	parameter int FREQ_BITS = nfcl_pkg::FREQ_BITS_DEF
) (
	input  wire logic [FREQ_BITS-1:0] freq,
	input  wire logic [FREQ_BITS-1:0] prev,
	input  wire logic [FREQ_BITS-1:0] cur,
	output nfcl_pkg::cmp_flags_t      flags
);

	logic [FREQ_BITS-1:0] d_req;
	logic [FREQ_BITS-1:0] d_span;

	// below the truncated midpoint: freq - prev < (cur - prev) / 2
	assign d_req  = freq - prev;
	assign d_span = cur - prev;

	assign flags.eq      = (freq == cur);
	assign flags.lt_cur  = (freq < cur);
	assign flags.gt_prev = (freq > prev);
	assign flags.lower   = (d_req < (d_span >> 1));

endmodule
`default_nettype wire

### rtl/nfcl_checker.sv
// Port-level checker for the calibration lookup, bound to the top level.
`default_nettype none
module nfcl_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [1:0]                    rsp_status,
	input wire logic [nfcl_pkg::IDX_W-1:0]    rsp_index,
	input wire logic [nfcl_pkg::VAL_W-1:0]    rsp_temp,
	input wire logic [nfcl_pkg::VAL_W-1:0]    rsp_i,
	input wire logic [nfcl_pkg::VAL_W-1:0]    rsp_q
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before transfer");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_index)
			&& $stable(rsp_temp) && $stable(rsp_i) && $stable(rsp_q))
		else $error("stalled response changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == nfcl_pkg::ST_FULL || rsp_status == nfcl_pkg::ST_EMPTY)
		|-> rsp_index == '0 && rsp_temp == '0 && rsp_i == '0 && rsp_q == '0)
		else $error("failed request returned nonzero entry data");

endmodule

bind nearest_frequency_cal_lookup nfcl_checker u_nfcl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_index  (rsp.entry_index),
	.rsp_temp   (rsp.found_temperature),
	.rsp_i      (rsp.found_i_offset),
	.rsp_q      (rsp.found_q_offset)
);
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the nearest-frequency calibration lookup table.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nfcl_pkg::*;

	localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [FREQ_IN_W-1:0] FREQ_MAX = '1;
	localparam int RANDOM_ITEMS = 560;
	localparam int CALM_ITEMS = 80;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [1:0]                   action;
		logic [FREQ_IN_W-1:0]         frequency;
		logic signed [VAL_W-1:0]      temperature;
		logic signed [VAL_W-1:0]      i_offset;
		logic signed [VAL_W-1:0]      q_offset;
	} cal_req_t;

	typedef struct packed {
		status_t                      status;
		logic [IDX_W-1:0]             entry_index;
		logic signed [VAL_W-1:0]      found_temperature;
		logic signed [VAL_W-1:0]      found_i_offset;
		logic signed [VAL_W-1:0]      found_q_offset;
	} cal_rsp_t;

	typedef struct {
		cal_req_t item;
		bit       typed;
		cal_rsp_t result;
	} table_row_t;

	typedef struct {
		bit       typed;
		cal_rsp_t result;
	} row_tag_t;

	logic clk = 1'b0;
	logic arst_n;

	nfcl_req_if req ();
	nfcl_rsp_if rsp ();

	nearest_frequency_cal_lookup i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predicted table contents
	logic [FREQ_IN_W-1:0] cal_freq [TABLE_DEPTH];
	entry_pay_t           cal_pay [TABLE_DEPTH];
	int unsigned          cal_count = 0;

	row_tag_t             row_tags[$];
	cal_rsp_t             expected_results[$];
	logic [FREQ_IN_W-1:0] stim_freqs[$];

	int  errors = 0;
	int  random_sent = 0;
	bit  calm = 1'b0;
	bit  source_idle = 1'b0;
	bit  sink_stall = 1'b0;
	int  n_lookups = 0, n_empty = 0, n_appends = 0, n_drops = 0, n_clears = 0, n_unused = 0;

	function automatic cal_req_t req_of(logic [1:0] a, int f, int t, int i, int q);
		cal_req_t r;
		r.action      = a;
		r.frequency   = FREQ_IN_W'(f);
		r.temperature = VAL_W'(t);
		r.i_offset    = VAL_W'(i);
		r.q_offset    = VAL_W'(q);
		return r;
	endfunction

	function automatic cal_rsp_t rsp_of(status_t s, int idx, int t, int i, int q);
		cal_rsp_t r;
		r.status            = s;
		r.entry_index       = IDX_W'(idx);
		r.found_temperature = VAL_W'(t);
		r.found_i_offset    = VAL_W'(i);
		r.found_q_offset    = VAL_W'(q);
		return r;
	endfunction

	function automatic int unsigned pick_nearest(logic [FREQ_IN_W-1:0] f);
		logic [FREQ_IN_W-1:0] cur, prev, mid;
		for (int k = 0; k < cal_count; k++) begin
			cur = cal_freq[k];
			if (f == cur)
				return k;
			if (k == 0) begin
				if (f < cur)
					return 0;
			end else begin
				prev = cal_freq[k-1];
				if (f > prev && f < cur) begin
					mid = prev + (cur - prev) / 2;
					return (f < mid) ? k - 1 : k;
				end
			end
		end
		return cal_count - 1;
	endfunction

	function automatic cal_rsp_t predict_response(cal_req_t r);
		cal_rsp_t    res;
		int unsigned k;
		res = '0;
		case (r.action)
			ACT_CLEAR: begin
				cal_count = 0;
			end
			ACT_APPEND: begin
				if (cal_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					cal_freq[cal_count] = r.frequency;
					cal_pay[cal_count]  = '{r.temperature, r.i_offset, r.q_offset};
					res.entry_index       = IDX_W'(cal_count);
					res.found_temperature = r.temperature;
					res.found_i_offset    = r.i_offset;
					res.found_q_offset    = r.q_offset;
					cal_count++;
				end
			end
			ACT_LOOKUP: begin
				if (cal_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					k = pick_nearest(r.frequency);
					res.entry_index       = IDX_W'(k);
					res.found_temperature = cal_pay[k].temp;
					res.found_i_offset    = cal_pay[k].i_off;
					res.found_q_offset    = cal_pay[k].q_off;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Called at a rising edge; returns at the edge of the transfer or after a gap
	task automatic send_request(cal_req_t r, bit typed, cal_rsp_t typed_rsp);
		row_tags.insert(row_tags.size(), '{typed, typed_rsp});
		req.valid       <= 1'b1;
		req.action      <= r.action;
		req.frequency   <= r.frequency;
		req.temperature <= r.temperature;
		req.i_offset    <= r.i_offset;
		req.q_offset    <= r.q_offset;
		do @(posedge clk); while (!req.ready);
		if (r.action == ACT_CLEAR)
			stim_freqs.delete();
		else if (r.action == ACT_APPEND && stim_freqs.size() < TABLE_DEPTH)
			stim_freqs.insert(stim_freqs.size(), r.frequency);
		if (source_idle && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (row_tags.size() + expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic maybe_send_noise();
		cal_req_t r;
		if ($urandom_range(0, 15) == 0) begin
			r = req_of(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
			send_request(r, 1'b0, '0);
			if (r.action != ACT_UNUSED)
				random_sent++;
		end
	endtask

	always @(posedge clk) begin : watch_requests
		cal_req_t accepted;
		row_tag_t tag;
		cal_rsp_t predicted;
		if (arst_n && req.valid && req.ready) begin
			accepted = '{req.action, req.frequency, req.temperature, req.i_offset,
				req.q_offset};
			predicted = predict_response(accepted);
			if (row_tags.size() == 0) begin
				tag = '{1'b0, predicted};
			end else begin
				tag = row_tags.pop_front();
			end
			expected_results.insert(expected_results.size(),
				tag.typed ? tag.result : predicted);
			case (accepted.action)
				ACT_CLEAR: n_clears++;
				ACT_APPEND: begin
					n_appends++;
					if (predicted.status == ST_FULL)
						n_drops++;
				end
				ACT_LOOKUP: begin
					n_lookups++;
					if (predicted.status == ST_EMPTY)
						n_empty++;
				end
				default: n_unused++;
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		cal_rsp_t want;
		bit       bad;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transfer, status %0d index %0d", $time,
					rsp.status, rsp.entry_index);
				errors++;
			end else begin
				want = expected_results.pop_front();
				bad  = 1'b0;
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, rsp.status);
					bad = 1'b1;
				end
				if (rsp.entry_index !== want.entry_index) begin
					$display("%0t: entry_index expected %0d actual %0d", $time,
						want.entry_index, rsp.entry_index);
					bad = 1'b1;
				end
				if (rsp.found_temperature !== want.found_temperature) begin
					$display("%0t: found_temperature expected %0d actual %0d", $time,
						want.found_temperature, rsp.found_temperature);
					bad = 1'b1;
				end
				if (rsp.found_i_offset !== want.found_i_offset) begin
					$display("%0t: found_i_offset expected %0d actual %0d", $time,
						want.found_i_offset, rsp.found_i_offset);
					bad = 1'b1;
				end
				if (rsp.found_q_offset !== want.found_q_offset) begin
					$display("%0t: found_q_offset expected %0d actual %0d", $time,
						want.found_q_offset, rsp.found_q_offset);
					bad = 1'b1;
				end
				if (bad)
					errors++;
			end
		end
	end

	always @(posedge clk) begin : drive_ready
		int stall_left;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else if (sink_stall && !calm && $urandom_range(0, 5) == 0) begin
			rsp.ready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("[nearest_frequency_cal_lookup] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		table_row_t           rows[$];
		logic [FREQ_IN_W:0]   next_freq;
		logic [FREQ_IN_W-1:0] probe, lo, hi;
		int                   n_app, k;
		bit                   sorted, tight, first_burst;

		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.action      = ACT_CLEAR;
		req.frequency   = '0;
		req.temperature = '0;
		req.i_offset    = '0;
		req.q_offset    = '0;
		rsp.ready       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_EMPTY, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, FREQ_MAX, -1, -1, -1), 1'b1,
			rsp_of(ST_EMPTY, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{req_of(ACT_UNUSED, FREQ_MAX, -1, -1, -1), 1'b1,
			rsp_of(ST_OK, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{req_of(ACT_APPEND, 1000, -32768, 32767, 0), 1'b1,
			rsp_of(ST_OK, 0, -32768, 32767, 0)});
		rows.insert(rows.size(), '{req_of(ACT_APPEND, 2000, 32767, -32768, -1), 1'b1,
			rsp_of(ST_OK, 1, 32767, -32768, -1)});
		rows.insert(rows.size(), '{req_of(ACT_APPEND, 2002, 1, 2, 3), 1'b1,
			rsp_of(ST_OK, 2, 1, 2, 3)});
		rows.insert(rows.size(), '{req_of(ACT_APPEND, FREQ_MAX, -1, -1, -1), 1'b1,
			rsp_of(ST_OK, 3, -1, -1, -1)});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 0, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 1000, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 1499, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 1500, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 2001, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 2002, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 3000, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, FREQ_MAX - 1, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, FREQ_MAX, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_UNUSED, 1234, 5, 6, 7), 1'b1,
			rsp_of(ST_OK, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 2000, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_CLEAR, FREQ_MAX, -1, -1, -1), 1'b1,
			rsp_of(ST_OK, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 1000, 0, 0, 0), 1'b1,
			rsp_of(ST_EMPTY, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{req_of(ACT_APPEND, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_OK, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, FREQ_MAX, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_APPEND, 0, 5, 6, 7), 1'b1,
			rsp_of(ST_OK, 1, 5, 6, 7)});
		rows.insert(rows.size(), '{req_of(ACT_LOOKUP, 0, 0, 0, 0), 1'b0, '0});
		rows.insert(rows.size(), '{req_of(ACT_CLEAR, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_OK, 0, 0, 0, 0)});

		source_idle = 1'b1;
		sink_stall  = 1'b1;
		foreach (rows[n])
			send_request(rows[n].item, rows[n].typed, rows[n].result);
		drain_results();

		// Random bursts: usually clear, refill the table, then probe near its entries, at the range ends and at random
		first_burst = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			calm        = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
			source_idle = !calm && $urandom_range(0, 2) != 0;
			sink_stall  = !calm && $urandom_range(0, 2) != 0;
			if (first_burst || $urandom_range(0, 3) != 0) begin
				send_request(req_of(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom),
					1'b0, '0);
				random_sent++;
			end
			if (first_burst)
				n_app = TABLE_DEPTH + 2;
			else if ($urandom_range(0, 3) == 0)
				n_app = $urandom_range(28, TABLE_DEPTH + 4);
			else
				n_app = $urandom_range(0, 8);
			sorted    = $urandom_range(0, 9) < 8;
			tight     = $urandom_range(0, 4) == 0;
			next_freq = (FREQ_IN_W + 1)'($urandom_range(0, 4096));
			repeat (n_app) begin
				if (sorted) begin
					probe = (next_freq > FREQ_MAX) ? FREQ_MAX : next_freq[FREQ_IN_W-1:0];
					next_freq = next_freq + (FREQ_IN_W + 1)'(tight ? $urandom_range(0, 3)
						: $urandom_range(1, 1 << 19));
				end else begin
					probe = FREQ_IN_W'($urandom);
				end
				send_request(req_of(ACT_APPEND, probe, $urandom, $urandom, $urandom),
					1'b0, '0);
				random_sent++;
				maybe_send_noise();
			end
			repeat ($urandom_range(2, 12)) begin
				if (stim_freqs.size() == 0) begin
					probe = FREQ_IN_W'($urandom);
				end else begin
					k = $urandom_range(0, stim_freqs.size() - 1);
					case ($urandom_range(0, 6))
						0: probe = stim_freqs[k];
						1: probe = stim_freqs[k] + 1'b1;
						2: probe = stim_freqs[k] - 1'b1;
						3, 4: begin
							lo = (k == 0) ? '0 : stim_freqs[k-1];
							hi = stim_freqs[k];
							probe = FREQ_IN_W'(lo + (hi - lo) / 2 + $urandom_range(0, 2) - 1);
						end
						5: probe = $urandom_range(0, 1) ? FREQ_MAX : '0;
						default: probe = FREQ_IN_W'($urandom);
					endcase
				end
				send_request(req_of(ACT_LOOKUP, probe, $urandom, $urandom, $urandom),
					1'b0, '0);
				random_sent++;
				maybe_send_noise();
			end
			if (!calm && $urandom_range(0, 5) == 0)
				drain_results();
			first_burst = 1'b0;
		end

		drain_results();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		$display("Covered %0d lookups (%0d on an empty table), %0d appends (%0d dropped full),",
			n_lookups, n_empty, n_appends, n_drops);
		$display("%0d clears and %0d unused action codes, with %0d mismatching results.",
			n_clears, n_unused, errors);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("[nearest_frequency_cal_lookup] OK");
		end else begin
			$display("[nearest_frequency_cal_lookup] ERROR");
		end
		$finish;
	end
endmodule

### filelist.f
rtl/nfcl_pkg.sv
rtl/nfcl_if.sv
rtl/nfcl_table.sv
rtl/nfcl_cmp.sv
rtl/nearest_frequency_cal_lookup.sv
rtl/nfcl_checker.sv
tb/tb_top.sv
